// ----- sv/psb_pkg.sv -----
// ----------------------------------------------------------------------------
// psb_pkg: shared types, constants and tables of the polar sector binner
// Point and result words, register indexes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int CordicIters = 24;
    localparam int CordicW     = 36;
    localparam int DefMaxBins  = 256;

    typedef struct packed {
        logic signed [15:0] point_z;
        logic signed [15:0] point_y;
        logic signed [15:0] point_x;
    } t_point;

    typedef struct packed {
        logic       hit;
        logic [7:0] bin_index;
    } t_result;

    typedef enum logic [2:0] {
        REG_CENTRE   = 3'd0,
        REG_AXIS_X   = 3'd1,
        REG_AXIS_Y   = 3'd2,
        REG_R_INNER  = 3'd3,
        REG_R_OUTER  = 3'd4,
        REG_A_START  = 3'd5,
        REG_A_END    = 3'd6,
        REG_BIN_CNT  = 3'd7
    } t_reg_idx;

    // Arctangent of 2^-i, 2^32 units per turn
    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] t;
        begin
            unique case (i)
                5'd0:  t = 30'h20000000;
                5'd1:  t = 30'h12E4051E;
                5'd2:  t = 30'h09FB385B;
                5'd3:  t = 30'h051111D4;
                5'd4:  t = 30'h028B0D43;
                5'd5:  t = 30'h0145D7E1;
                5'd6:  t = 30'h00A2F61E;
                5'd7:  t = 30'h00517C55;
                5'd8:  t = 30'h0028BE53;
                5'd9:  t = 30'h00145F2F;
                5'd10: t = 30'h000A2F98;
                5'd11: t = 30'h000517CC;
                5'd12: t = 30'h00028BE6;
                5'd13: t = 30'h000145F3;
                5'd14: t = 30'h0000A2F9;
                5'd15: t = 30'h0000517C;
                5'd16: t = 30'h000028BE;
                5'd17: t = 30'h0000145F;
                5'd18: t = 30'h00000A2F;
                5'd19: t = 30'h00000517;
                5'd20: t = 30'h0000028B;
                5'd21: t = 30'h00000145;
                5'd22: t = 30'h000000A2;
                5'd23: t = 30'h00000051;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

// ----- sv/psb_cordic.sv -----
// ----------------------------------------------------------------------------
// psb_cordic: pipelined vectoring CORDIC
// One micro-rotation per stage; carries a tag word alongside each vector.
// ----------------------------------------------------------------------------
module psb_cordic #(
    parameter int TagW = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [psb_pkg::CordicW-1:0] i_x,
    input  logic signed [psb_pkg::CordicW-1:0] i_y,
    input  logic signed [psb_pkg::CordicW-1:0] i_acc,
    input  logic [TagW-1:0]                   i_tag,
    output logic                              o_valid,
    output logic signed [psb_pkg::CordicW-1:0] o_acc,
    output logic [TagW-1:0]                   o_tag
);
    import psb_pkg::*;

    localparam int N = CordicIters;
    localparam int W = CordicW;

    logic              r_v   [N];
    logic signed [W-1:0] r_x   [N];
    logic signed [W-1:0] r_y   [N];
    logic signed [W-1:0] r_acc [N];
    logic [TagW-1:0]   r_tag [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic                w_v;
        logic signed [W-1:0] w_x, w_y, w_acc;
        logic [TagW-1:0]     w_tag;
        logic signed [W-1:0] n_x, n_y, n_acc, w_t;
        if (g == 0) begin : g_src
            always_comb begin
                w_v   = i_valid;
                w_x   = i_x;
                w_y   = i_y;
                w_acc = i_acc;
                w_tag = i_tag;
            end
        end else begin : g_src
            always_comb begin
                w_v   = r_v[g-1];
                w_x   = r_x[g-1];
                w_y   = r_y[g-1];
                w_acc = r_acc[g-1];
                w_tag = r_tag[g-1];
            end
        end
        always_comb begin
            w_t = W'(atan_lut(5'(g)));
            if (!w_y[W-1]) begin
                n_x   = w_x + (w_y >>> g);
                n_y   = w_y - (w_x >>> g);
                n_acc = w_acc + w_t;
            end else begin
                n_x   = w_x - (w_y >>> g);
                n_y   = w_y + (w_x >>> g);
                n_acc = w_acc - w_t;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= w_v;
            end
            r_x[g]   <= n_x;
            r_y[g]   <= n_y;
            r_acc[g] <= n_acc;
            r_tag[g] <= w_tag;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_acc   = r_acc[N-1];
    assign o_tag   = r_tag[N-1];

endmodule

// ----- sv/polar_sector_binner.sv -----
// ----------------------------------------------------------------------------
// polar_sector_binner: angular histogram binning of 3-D points
// Projects a point about a centre onto two axes and bins its polar angle.
// ----------------------------------------------------------------------------
// A point word is taken at every clock edge where i_start is high and o_busy
// is low; o_busy is tied low, so one point enters per cycle. The result word
// is held for one cycle with o_done high once the point has passed through
// the pipeline: a difference stage, a product stage, a sum-and-round stage,
// a classify stage, 24 CORDIC micro-rotations, a bin multiply stage, CW
// restoring division stages (nine at the default MAX_BINS) and the result
// register. The receiver cannot stall, so nothing is held back.
// The user must write registers through i_cfg_we/i_cfg_idx/i_cfg_data only
// while no point is in flight; the block itself does not enforce this.
module polar_sector_binner #(
    parameter int MAX_BINS = psb_pkg::DefMaxBins
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  psb_pkg::t_point   i_point,
    output logic              o_done,
    output psb_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [47:0]       i_cfg_data
);
    import psb_pkg::*;

    localparam int CW = $clog2(MAX_BINS + 1);

    // ---------------- configuration registers
    logic [47:0] r_centre, r_ax, r_ay;
    logic [15:0] r_rin, r_rout, r_astart;
    logic [16:0] r_aend;
    logic [8:0]  r_bcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre <= '0; r_ax <= '0; r_ay <= '0;
            r_rin <= '0; r_rout <= 16'hFFFF; r_astart <= '0;
            r_aend <= 17'h10000; r_bcnt <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CENTRE:  r_centre <= i_cfg_data;
                REG_AXIS_X:  r_ax     <= i_cfg_data;
                REG_AXIS_Y:  r_ay     <= i_cfg_data;
                REG_R_INNER: r_rin    <= i_cfg_data[15:0];
                REG_R_OUTER: r_rout   <= i_cfg_data[15:0];
                REG_A_START: r_astart <= i_cfg_data[15:0];
                REG_A_END:   r_aend   <= i_cfg_data[16:0];
                REG_BIN_CNT: r_bcnt   <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Clamp count to MAX_BINS; derived config values follow the registers directly
    logic [CW-1:0] w_cnt;
    logic [16:0]   w_span;
    logic          w_cfg_ok;
    always_comb begin
        if ({23'd0, r_bcnt} > MAX_BINS) w_cnt = CW'(MAX_BINS);
        else                            w_cnt = CW'(r_bcnt);
        w_span   = r_aend - {1'b0, r_astart};
        w_cfg_ok = (w_cnt != '0) && (r_aend > {1'b0, r_astart});
    end

    assign o_busy = 1'b0;
    logic w_acc_in;
    assign w_acc_in = i_start && !o_busy;

    // ---------------- stage 1: difference
    logic               r1_v;
    logic signed [16:0] r1_d [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= w_acc_in;
        r1_d[0] <= 17'(i_point.point_x) - 17'(signed'(r_centre[15:0]));
        r1_d[1] <= 17'(i_point.point_y) - 17'(signed'(r_centre[31:16]));
        r1_d[2] <= 17'(i_point.point_z) - 17'(signed'(r_centre[47:32]));
    end

    // ---------------- stage 2: products
    logic               r2_v;
    logic signed [32:0] r2_pu [3];
    logic signed [32:0] r2_pv [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        for (int k = 0; k < 3; k++) begin
            r2_pu[k] <= 33'(r1_d[k]) * 33'(signed'(r_ay[16*k +: 16]));
            r2_pv[k] <= 33'(r1_d[k]) * 33'(signed'(r_ax[16*k +: 16]));
        end
    end

    // ---------------- stage 3: sum and round off the low 10 bits
    logic               r3_v;
    logic signed [24:0] r3_u, r3_v_c;
    logic signed [34:0] n3_su, n3_sv;
    always_comb begin
        n3_su = 35'(r2_pu[0]) + 35'(r2_pu[1]) + 35'(r2_pu[2]) + 35'sd512;
        n3_sv = 35'(r2_pv[0]) + 35'(r2_pv[1]) + 35'(r2_pv[2]) + 35'sd512;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_u   <= n3_su[34:10];
        r3_v_c <= n3_sv[34:10];
    end

    // ---------------- stage 4: squares, classify, CORDIC set-up
    logic               r4_v;
    logic signed [49:0] r4_uu, r4_vv;
    logic signed [CordicW-1:0] r4_x, r4_y, r4_acc;
    logic [1:0]         r4_sp;   // 0 cordic, 1 zero angle, 2 half, 3 quarter
    logic               r4_neg;
    logic signed [24:0] w4_w;
    always_comb begin
        w4_w = r3_v_c[24] ? -r3_v_c : r3_v_c;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_uu  <= 50'(r3_u) * 50'(r3_u);
        r4_vv  <= 50'(r3_v_c) * 50'(r3_v_c);
        r4_neg <= r3_v_c[24];
        if (r3_v_c == '0)    r4_sp <= r3_u[24] ? 2'd2 : 2'd1;
        else if (r3_u == '0) r4_sp <= 2'd3;
        else                 r4_sp <= 2'd0;
        if (r3_u[24]) begin
            r4_x   <= CordicW'(w4_w) <<< 8;
            r4_y   <= (-CordicW'(r3_u)) <<< 8;
            r4_acc <= CordicW'(1) << 30;
        end else begin
            r4_x   <= CordicW'(r3_u) <<< 8;
            r4_y   <= CordicW'(w4_w) <<< 8;
            r4_acc <= '0;
        end
    end

    // ---------------- radius test before CORDIC, tag travels with the vector
    logic [39:0] w_lin, w_lout;
    logic [50:0] w_rsq;
    logic        w_rad_ok;
    always_comb begin
        w_lin    = 40'({r_rin, 4'd0}) * 40'({r_rin, 4'd0});
        w_lout   = 40'({r_rout, 4'd0}) * 40'({r_rout, 4'd0});
        w_rsq    = 51'(unsigned'(r4_uu)) + 51'(unsigned'(r4_vv));
        w_rad_ok = !(w_rsq < 51'(w_lin)) && !(w_rsq > 51'(w_lout));
    end

    localparam int TagW = 4;
    logic            w5_v;
    logic signed [CordicW-1:0] w5_acc;
    logic [TagW-1:0] w5_tag;

    psb_cordic #(.TagW(TagW)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_x     (r4_x),
        .i_y     (r4_y),
        .i_acc   (r4_acc),
        .i_tag   ({w_rad_ok, r4_neg, r4_sp}),
        .o_valid (w5_v),
        .o_acc   (w5_acc),
        .o_tag   (w5_tag)
    );

    // ---------------- stage 6: angle, range test, product
    logic [16:0] n6_theta, n6_angle;
    logic [16:0] n6_off;
    logic        n6_in;
    logic signed [CordicW-17:0] w6_a;
    always_comb begin
        w6_a = w5_acc[CordicW-1:16];
        if (w6_a < 0)           n6_theta = '0;
        else if (w6_a > 32768)  n6_theta = 17'd32768;
        else                    n6_theta = 17'(w6_a);
        unique case (w5_tag[1:0])
            2'd1:    n6_theta = '0;
            2'd2:    n6_theta = 17'd32768;
            2'd3:    n6_theta = 17'd16384;
            default: ;
        endcase
        n6_angle = w5_tag[2] ? 17'h10000 - n6_theta : n6_theta;
        n6_in    = w5_tag[3] && w_cfg_ok && (n6_angle >= {1'b0, r_astart})
                   && (n6_angle <= r_aend);
        n6_off   = n6_angle - {1'b0, r_astart};
    end

    logic              r6_v, r6_in;
    logic [16+CW-1:0]  r6_prod;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else          r6_v <= w5_v;
        r6_in   <= n6_in;
        r6_prod <= (16+CW)'(n6_off) * (16+CW)'(w_cnt);
    end

    // ---------------- stage 7: quotient search by bin boundaries.
    // n = floor(prod/span); prod <= cnt*span so n <= cnt. Compute via
    // restoring division, one bit per stage, CW stages.
    logic              r7_v   [CW];
    logic              r7_in  [CW];
    logic [16+CW-1:0]  r7_rem [CW];
    logic [CW-1:0]     r7_q   [CW];
    for (genvar g = 0; g < CW; g++) begin : g_div
        localparam int B = CW - 1 - g;
        logic             w_v, w_in;
        logic [16+CW-1:0] w_rem;
        logic [CW-1:0]    w_q;
        logic [16+CW-1:0] w_sub;
        logic             w_ge;
        if (g == 0) begin : g_src
            always_comb begin
                w_v   = r6_v;
                w_in  = r6_in;
                w_rem = r6_prod;
                w_q   = '0;
            end
        end else begin : g_src
            always_comb begin
                w_v   = r7_v[g-1];
                w_in  = r7_in[g-1];
                w_rem = r7_rem[g-1];
                w_q   = r7_q[g-1];
            end
        end
        always_comb begin
            w_sub = (16+CW)'(w_span) << B;
            w_ge  = w_rem >= w_sub;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r7_v[g] <= 1'b0;
            else          r7_v[g] <= w_v;
            r7_in[g]  <= w_in;
            r7_rem[g] <= w_ge ? w_rem - w_sub : w_rem;
            r7_q[g]   <= w_ge ? (w_q | (CW'(1) << B)) : w_q;
        end
    end

    // ---------------- output register: clamp end hit, drive strobe
    logic    r_done;
    t_result r_res;
    logic [CW-1:0] w_n;
    always_comb begin
        w_n = (r7_q[CW-1] >= w_cnt) ? w_cnt - CW'(1) : r7_q[CW-1];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r7_v[CW-1];
        r_res.hit       <= r7_in[CW-1];
        r_res.bin_index <= r7_in[CW-1] ? 8'(w_n) : 8'd0;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // ---------------- checks
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.hit |-> o_result.bin_index == 8'd0)
        else $error("miss with non-zero bin");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r7_v[CW-1] |=> o_done)
        else $error("result strobe lost");
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r7_v[CW-1] && r7_in[CW-1] |-> r7_q[CW-1] <= w_cnt)
        else $error("bin quotient beyond count");

endmodule
